[design/tbag_pkg.sv]
// ---------------------------------------------------------------------------
// tbag_pkg
// Shared register index codes for the broadcast address generator.
// ---------------------------------------------------------------------------
package tbag_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int RANK_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_RANK    = 3'd0,
    REG_FIRST_RANK  = 3'd1,
    REG_SECOND_RANK = 3'd2,
    REG_OUT_DIMS    = 3'd3,
    REG_FIRST_DIMS  = 3'd4,
    REG_SECOND_DIMS = 3'd5
  } cfg_reg_t;

endpackage

[design/tensor_broadcast_address_generator.sv]
// Takes one linear output index per cycle (busy stays low) and returns the output offset and
// the two operand offsets with their valid flags, one result per cycle on out_valid. For each
// dimension the pipeline holds INDEX_BITS one-bit restoring-divider stages, then a multiply
// stage and an accumulate stage.
// The receiver cannot stall, and configuration must be written while no request is in flight.
// ---------------------------------------------------------------------------
// tensor_broadcast_address_generator
// Pipelined coordinate split and strided offset build for two broadcast operands.
// ---------------------------------------------------------------------------
module tensor_broadcast_address_generator
  import tbag_pkg::*;
#(
  parameter int MAX_DIMS    = 4,
  parameter int EXTENT_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_idx,
  input  logic [MAX_DIMS*EXTENT_BITS-1:0] cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic [INDEX_BITS-1:0]           in_linear_index,
  output logic                            out_valid,
  output logic [INDEX_BITS-1:0]           out_out_offset,
  output logic [INDEX_BITS-1:0]           out_first_offset,
  output logic                            out_first_valid,
  output logic [INDEX_BITS-1:0]           out_second_offset,
  output logic                            out_second_valid
);

  localparam int DW      = MAX_DIMS * EXTENT_BITS;
  localparam int SEG     = INDEX_BITS + 2;
  localparam int NSTAGES = MAX_DIMS * SEG;

  typedef struct packed {
    logic                   vld;
    logic [INDEX_BITS-1:0]  dq;
    logic [EXTENT_BITS-1:0] rem;
    logic [INDEX_BITS-1:0]  pro;
    logic [INDEX_BITS-1:0]  prf;
    logic [INDEX_BITS-1:0]  prs;
    logic [INDEX_BITS-1:0]  stro;
    logic [INDEX_BITS-1:0]  strf;
    logic [INDEX_BITS-1:0]  strs;
    logic [INDEX_BITS-1:0]  acco;
    logic [INDEX_BITS-1:0]  accf;
    logic [INDEX_BITS-1:0]  accs;
    logic                   badf;
    logic                   bads;
  } stg_t;

  localparam int SW = $bits(stg_t);

  logic [RANK_W-1:0] out_rank_r, first_rank_r, second_rank_r;
  logic [DW-1:0]     out_dims_r, first_dims_r, second_dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rank_r    <= RANK_W'(1);
      first_rank_r  <= RANK_W'(1);
      second_rank_r <= RANK_W'(1);
      out_dims_r    <= DW'(1);
      first_dims_r  <= DW'(1);
      second_dims_r <= DW'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OUT_RANK:    out_rank_r    <= cfg_wdata[RANK_W-1:0];
        REG_FIRST_RANK:  first_rank_r  <= cfg_wdata[RANK_W-1:0];
        REG_SECOND_RANK: second_rank_r <= cfg_wdata[RANK_W-1:0];
        REG_OUT_DIMS:    out_dims_r    <= cfg_wdata;
        REG_FIRST_DIMS:  first_dims_r  <= cfg_wdata;
        REG_SECOND_DIMS: second_dims_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  stg_t cur [0:NSTAGES];
  stg_t in_stg;

  always_comb begin
    in_stg      = '0;
    in_stg.vld  = start;
    in_stg.dq   = in_linear_index;
    in_stg.stro = INDEX_BITS'(1);
    in_stg.strf = INDEX_BITS'(1);
    in_stg.strs = INDEX_BITS'(1);
  end

  assign cur[0] = in_stg;

  genvar s;
  generate
    for (s = 0; s < NSTAGES; s++) begin : g_stage
      localparam int J = s % SEG;
      localparam int D = MAX_DIMS - 1 - s / SEG;

      stg_t            stg_nxt;
      logic            vld_r;
      logic [SW-2:0]   dat_r;

      if (J < INDEX_BITS) begin : g_div
        logic [EXTENT_BITS-1:0] e_o;
        logic                   use_o, skip;
        logic [EXTENT_BITS-1:0] rem_in;
        logic [EXTENT_BITS:0]   t;
        logic                   ge;
        assign e_o    = out_dims_r[D*EXTENT_BITS +: EXTENT_BITS];
        assign use_o  = 32'(D) < 32'(out_rank_r);
        // dimension outside the output rank or of zero extent passes the quotient through
        assign skip   = !use_o || (e_o == '0);
        assign rem_in = (J == 0) ? '0 : cur[s].rem;
        assign t      = {rem_in, cur[s].dq[INDEX_BITS-1]};
        assign ge     = t >= {1'b0, e_o};
        always_comb begin
          stg_nxt = cur[s];
          if (!skip) begin
            stg_nxt.rem = ge ? EXTENT_BITS'(t - {1'b0, e_o}) : t[EXTENT_BITS-1:0];
            stg_nxt.dq  = {cur[s].dq[INDEX_BITS-2:0], ge};
          end else begin
            stg_nxt.rem = '0;
          end
        end
      end else if (J == INDEX_BITS) begin : g_mul
        logic [EXTENT_BITS-1:0] e_o, e_f, e_s;
        logic                   use_o, use_f, use_s, skip;
        logic [EXTENT_BITS-1:0] crd;
        assign e_o   = out_dims_r[D*EXTENT_BITS +: EXTENT_BITS];
        assign e_f   = first_dims_r[D*EXTENT_BITS +: EXTENT_BITS];
        assign e_s   = second_dims_r[D*EXTENT_BITS +: EXTENT_BITS];
        assign use_o = 32'(D) < 32'(out_rank_r);
        assign use_f = 32'(D) < 32'(first_rank_r);
        assign use_s = 32'(D) < 32'(second_rank_r);
        assign skip  = !use_o || (e_o == '0);
        assign crd   = skip ? '0 : cur[s].rem;
        always_comb begin
          stg_nxt     = cur[s];
          stg_nxt.pro = INDEX_BITS'(crd * cur[s].stro);
          stg_nxt.prf = use_f ? INDEX_BITS'(crd * cur[s].strf) : '0;
          stg_nxt.prs = use_s ? INDEX_BITS'(crd * cur[s].strs) : '0;
          if (use_o) stg_nxt.stro = INDEX_BITS'(cur[s].stro * e_o);
          if (use_f) stg_nxt.strf = INDEX_BITS'(cur[s].strf * e_f);
          if (use_s) stg_nxt.strs = INDEX_BITS'(cur[s].strs * e_s);
          stg_nxt.badf = cur[s].badf || (use_f && ((e_f == '0) || (crd >= e_f)));
          stg_nxt.bads = cur[s].bads || (use_s && ((e_s == '0) || (crd >= e_s)));
        end
      end else begin : g_acc
        always_comb begin
          stg_nxt      = cur[s];
          stg_nxt.acco = cur[s].acco + cur[s].pro;
          stg_nxt.accf = cur[s].accf + cur[s].prf;
          stg_nxt.accs = cur[s].accs + cur[s].prs;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r <= 1'b0;
        end else begin
          vld_r <= stg_nxt.vld;
        end
      end

      always_ff @(posedge clk) begin
        dat_r <= stg_nxt[SW-2:0];
      end

      assign cur[s+1] = {vld_r, dat_r};
    end
  endgenerate

  logic ok_f, ok_s, fv, sv;
  stg_t last;

  assign last = cur[NSTAGES];
  assign ok_f = (first_rank_r != '0) && (first_rank_r <= out_rank_r);
  assign ok_s = (second_rank_r != '0) && (second_rank_r <= out_rank_r);
  assign fv   = ok_f && !last.badf;
  assign sv   = ok_s && !last.bads;

  assign out_valid         = last.vld;
  assign out_out_offset    = (out_rank_r == '0) ? '0 : last.acco;
  assign out_first_valid   = fv;
  assign out_first_offset  = fv ? last.accf : '0;
  assign out_second_valid  = sv;
  assign out_second_offset = sv ? last.accs : '0;

endmodule
